### design/cmwtg_pkg.sv
// ----------------------------------------------------------------------------
// Cyclic match walk text generator package
// Default sizes, operation codes and sequencer states shared by the block.
// ----------------------------------------------------------------------------
package cmwtg_pkg;

	localparam int unsigned STORE_DEPTH_DEF  = 4096;
	localparam int unsigned VOCAB_SIZE_DEF   = 1024;
	localparam int unsigned REPEAT_LIMIT_DEF = 5;

	typedef enum logic [1:0] {
		OP_CLEAR = 2'd0,
		OP_LOAD  = 2'd1,
		OP_START = 2'd2,
		OP_GEN   = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TGTW,
		ST_SRCH,
		ST_ADV,
		ST_EMIT
	} state_t;

endpackage

### design/cmwtg_wrap_inc.sv
// ----------------------------------------------------------------------------
// Cyclic match walk wrapping incrementer
// Steps a sequence position by one and wraps to zero at the word count.
// ----------------------------------------------------------------------------
module cmwtg_wrap_inc #(
	parameter int unsigned POS_W = 12,
	parameter int unsigned CNT_W = 13
) (
	input  logic [POS_W-1:0] pos,
	input  logic [CNT_W-1:0] count,
	output logic [POS_W-1:0] next_pos
);

	logic [CNT_W:0] sum;

	assign sum      = (CNT_W+1)'(pos) + (CNT_W+1)'(1);
	assign next_pos = (sum >= {1'b0, count}) ? '0 : sum[POS_W-1:0];

endmodule

### design/cyclic_match_walk_text_generator_core.sv
// ----------------------------------------------------------------------------
// Cyclic match walk text generator core
// Holds a sequence of word symbols and walks it bigram style.
// ----------------------------------------------------------------------------
// An item is taken at a rising edge with start high and busy low. Clear and
// load finish at that edge and leave busy low. Start and generate raise busy
// and produce exactly one result, shown for one cycle with done high; the
// receiver cannot hold it off, so results are never stalled.
// Start gives its result in the cycle after it is taken. Generate with a
// zero repeat count goes straight to advancing the cursor; otherwise it
// registers the symbol at the cursor as target, then searches forward for
// as many matches as the repeat count, then advances the cursor. The
// search reads one store entry per cycle through the single read port of
// the word memory and compares it with the target symbol in one comparator.
// Errors (empty store, start position not below the count) give their
// result in the cycle after the item is taken, with zero symbol and position.
// start_position_we writes the start position register; the user must only
// write it while idle, the block does not enforce it. Reset clears count,
// cursor and start position; the word memory needs no clearing.
// ----------------------------------------------------------------------------
module cyclic_match_walk_text_generator_core #(
	parameter int unsigned STORE_DEPTH  = cmwtg_pkg::STORE_DEPTH_DEF,
	parameter int unsigned VOCAB_SIZE   = cmwtg_pkg::VOCAB_SIZE_DEF,
	parameter int unsigned REPEAT_LIMIT = cmwtg_pkg::REPEAT_LIMIT_DEF,
	localparam int unsigned POS_W = $clog2(STORE_DEPTH),
	localparam int unsigned CNT_W = $clog2(STORE_DEPTH + 1),
	localparam int unsigned SYM_W = $clog2(VOCAB_SIZE),
	localparam int unsigned REP_W = $clog2(REPEAT_LIMIT + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  logic [1:0]       operation,
	input  logic [SYM_W-1:0] word_symbol,
	input  logic [REP_W-1:0] repeat_count,
	input  logic             start_position_we,
	input  logic [POS_W-1:0] start_position,
	output logic             done,
	output logic [SYM_W-1:0] emitted_symbol,
	output logic [POS_W-1:0] emitted_position,
	output logic             error
);

	cmwtg_pkg::state_t state_q, state_d;

	logic [SYM_W-1:0] mem [STORE_DEPTH];
	logic [SYM_W-1:0] rd_data_q;
	logic [POS_W-1:0] rd_addr;
	logic             wr_en;

	logic [CNT_W-1:0] count_q;
	logic [POS_W-1:0] cursor_q;
	logic [POS_W-1:0] start_pos_q;
	logic             err_q;
	logic [REP_W-1:0] rep_left_q;
	logic [SYM_W-1:0] target_q;
	logic [POS_W-1:0] addr_s1;

	logic             accept;
	cmwtg_pkg::op_t   op;
	logic [POS_W-1:0] cursor_g;
	logic [REP_W-1:0] rep_sat;
	logic             start_err;
	logic             gen_err;
	logic             match;
	logic [POS_W-1:0] inc_in;
	logic [POS_W-1:0] inc_out;

	assign accept    = start && !busy;
	assign op        = cmwtg_pkg::op_t'(operation);
	assign cursor_g  = (CNT_W'(cursor_q) >= count_q) ? '0 : cursor_q;
	assign rep_sat   = (repeat_count > REP_W'(REPEAT_LIMIT - 1)) ?
		REP_W'(REPEAT_LIMIT - 1) : repeat_count;
	assign start_err = (CNT_W'(start_pos_q) >= count_q);
	assign gen_err   = (count_q == '0);
	assign match     = (rd_data_q == target_q);
	assign wr_en     = accept && (op == cmwtg_pkg::OP_LOAD) &&
		(count_q < CNT_W'(STORE_DEPTH));
	assign inc_in    = (state_q == cmwtg_pkg::ST_SRCH) ? addr_s1 : cursor_q;

	cmwtg_wrap_inc #(
		.POS_W (POS_W),
		.CNT_W (CNT_W)
	) u_wrap_inc (
		.pos      (inc_in),
		.count    (count_q),
		.next_pos (inc_out)
	);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[count_q[POS_W-1:0]] <= word_symbol;
		end
		rd_data_q <= mem[rd_addr];
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			cmwtg_pkg::ST_IDLE: begin
				if (accept) begin
					case (op)
						cmwtg_pkg::OP_START: state_d = cmwtg_pkg::ST_EMIT;
						cmwtg_pkg::OP_GEN: begin
							if (gen_err) begin
								state_d = cmwtg_pkg::ST_EMIT;
							end else if (rep_sat == '0) begin
								state_d = cmwtg_pkg::ST_ADV;
							end else begin
								state_d = cmwtg_pkg::ST_TGTW;
							end
						end
						default: state_d = cmwtg_pkg::ST_IDLE;
					endcase
				end
			end
			cmwtg_pkg::ST_TGTW: state_d = cmwtg_pkg::ST_SRCH;
			cmwtg_pkg::ST_SRCH: begin
				if (match && rep_left_q == REP_W'(1)) begin
					state_d = cmwtg_pkg::ST_ADV;
				end
			end
			cmwtg_pkg::ST_ADV:  state_d = cmwtg_pkg::ST_EMIT;
			cmwtg_pkg::ST_EMIT: state_d = cmwtg_pkg::ST_IDLE;
			default:            state_d = cmwtg_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		busy    = 1'b1;
		done    = 1'b0;
		rd_addr = inc_out;
		unique case (state_q)
			cmwtg_pkg::ST_IDLE: begin
				busy    = 1'b0;
				rd_addr = (op == cmwtg_pkg::OP_GEN) ? cursor_g : start_pos_q;
			end
			cmwtg_pkg::ST_TGTW, cmwtg_pkg::ST_SRCH, cmwtg_pkg::ST_ADV: begin
				rd_addr = inc_out;
			end
			cmwtg_pkg::ST_EMIT: done = 1'b1;
			default: busy = 1'b1;
		endcase
	end

	assign emitted_symbol   = (done && !err_q) ? rd_data_q : '0;
	assign emitted_position = (done && !err_q) ? cursor_q : '0;
	assign error            = done && err_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= cmwtg_pkg::ST_IDLE;
			count_q     <= '0;
			cursor_q    <= '0;
			start_pos_q <= '0;
			err_q       <= 1'b0;
			rep_left_q  <= '0;
		end else begin
			state_q <= state_d;
			if (start_position_we) begin
				start_pos_q <= start_position;
			end
			unique case (state_q)
				cmwtg_pkg::ST_IDLE: begin
					if (accept) begin
						case (op)
							cmwtg_pkg::OP_CLEAR: begin
								count_q  <= '0;
								cursor_q <= '0;
							end
							cmwtg_pkg::OP_LOAD: begin
								if (wr_en) begin
									count_q <= count_q + CNT_W'(1);
								end
							end
							cmwtg_pkg::OP_START: begin
								err_q <= start_err;
								if (!start_err) begin
									cursor_q <= start_pos_q;
								end
							end
							default: begin
								err_q      <= gen_err;
								rep_left_q <= rep_sat;
								if (!gen_err) begin
									cursor_q <= cursor_g;
								end
							end
						endcase
					end
				end
				cmwtg_pkg::ST_SRCH: begin
					if (match) begin
						cursor_q   <= addr_s1;
						rep_left_q <= rep_left_q - REP_W'(1);
					end
				end
				cmwtg_pkg::ST_ADV: cursor_q <= inc_out;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= rd_addr;
		if (state_q == cmwtg_pkg::ST_TGTW) begin
			target_q <= rd_data_q;
		end
	end

endmodule

### design/cmwtg_checker.sv
// ----------------------------------------------------------------------------
// Cyclic match walk text generator port checker
// Watches the top level ports for handshake and result ordering slips.
// ----------------------------------------------------------------------------
module cmwtg_checker #(
	parameter int unsigned SYM_W = 10,
	parameter int unsigned POS_W = 12
) (
	input logic             clk,
	input logic             arst_n,
	input logic             start,
	input logic             busy,
	input logic [1:0]       operation,
	input logic             done,
	input logic [SYM_W-1:0] emitted_symbol,
	input logic [POS_W-1:0] emitted_position,
	input logic             error
);

	a_done_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("Result shown while the block is idle.");

	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		error |-> (done && emitted_symbol == '0 && emitted_position == '0))
		else $error("Error result carries nonzero payload.");

	a_done_ends: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy && !done)
		else $error("Block stays busy after its result.");

	a_quiet_ops: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (operation == cmwtg_pkg::OP_CLEAR ||
			operation == cmwtg_pkg::OP_LOAD)) |=> !busy)
		else $error("Clear or load item made the block busy.");

	a_result_ops: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (operation == cmwtg_pkg::OP_START ||
			operation == cmwtg_pkg::OP_GEN)) |=> busy)
		else $error("Start or generate item did not make the block busy.");

endmodule

bind cyclic_match_walk_text_generator_core cmwtg_checker #(
	.SYM_W ($clog2(VOCAB_SIZE)),
	.POS_W ($clog2(STORE_DEPTH))
) u_cmwtg_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.start            (start),
	.busy             (busy),
	.operation        (operation),
	.done             (done),
	.emitted_symbol   (emitted_symbol),
	.emitted_position (emitted_position),
	.error            (error)
);
